>>> rtl/scmsl_pkg.sv
// Package for the scalar multiply-subtract modulo group order block.
// Holds the group order, the Barrett constant and the multiply-unit command type.
// Depends on nothing.
`default_nettype none
package scmsl_pkg;

	localparam int DIG_W   = 32;
	localparam int LIMB_W  = 64;
	localparam int WIDE_W  = 256;
	localparam int BUF_W   = 512;

	// Group order l = 2^252 + 0x14def9dea2f79cd65812631a5cf5d3ed.
	localparam logic [WIDE_W-1:0] ORDER_L =
		{64'h1000000000000000, 64'h0000000000000000,
		 64'h14def9dea2f79cd6, 64'h5812631a5cf5d3ed};

	// Barrett constant floor(2^506 / l).
	localparam logic [WIDE_W-1:0] BARRETT_MU =
		{64'h3fffffffffffffff, 64'hffffffffffffffff,
		 64'hac84188574218ca6, 64'h9fb673968c28b04c};

	localparam logic [LIMB_W-1:0] TOP_MASK = 64'h1FFFFFFFFFFFFFFF;

	typedef struct packed {
		logic             valid;
		logic             col_end;
		logic [3:0]       col;
		logic [DIG_W-1:0] x;
		logic [DIG_W-1:0] y;
		logic             flush;
	} mac_cmd_t;

endpackage
`default_nettype wire

>>> rtl/scalar_mulsub_mod_group_order_unit.sv
// Top level: s = (c - a*b) mod l for the Ed25519 group order l.
// Depends on scmsl_pkg and scmsl_mac.
//
// Usage. Input items arrive on the s_ group; each carries limb_index and one
// 64-bit limb of a, b and c. Limbs are stored at their index, the latest write
// to a position wins. An item with limb_index 3 stores its limbs and starts the
// computation. Items with index 0 to 2 only store their limbs and produce nothing.
// The computation runs three 256x256-bit products on one shared 32x32
// multiplier, one digit product per cycle: a*b (64 products), the Barrett
// quotient estimate times mu (64 products) and the quotient times l (36
// products), each followed by the drain, flush and capture states. Then three
// 256-bit subtract steps follow: two conditional subtracts of l, then c - t mod l.
// Results leave on the m_ group as four items, least significant limb first,
// with m_tlast on the fourth. s_tready is low from the index-3 item until the
// last result item is taken. A stalled receiver simply holds the block in its
// output state with the current item steady on m_tdata.
// Reset clears the sequencer; the stored limbs are undefined until written.
`default_nettype none
module scalar_mulsub_mod_group_order_unit import scmsl_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// bits from 0: limb_index[1:0], a_limb[63:0], b_limb[63:0], c_limb[63:0], zero pad
	input  wire logic [199:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// bits from 0: result_limb[63:0], result_index[1:0], zero pad
	output logic [71:0]       m_tdata,
	output logic              m_tlast
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_DRAIN = 4'd2;
	localparam logic [3:0] ST_FLUSH = 4'd3;
	localparam logic [3:0] ST_NEXT  = 4'd4;
	localparam logic [3:0] ST_CS1   = 4'd5;
	localparam logic [3:0] ST_CS2   = 4'd6;
	localparam logic [3:0] ST_FIN   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	localparam logic [1:0] PH_AB = 2'd0;
	localparam logic [1:0] PH_MU = 2'd1;
	localparam logic [1:0] PH_L  = 2'd2;

	logic [3:0]        state_q;
	logic [1:0]        phase_q;
	logic [3:0]        k_q;
	logic [2:0]        i_q;
	logic [1:0]        oidx_q;

	logic [LIMB_W-1:0] a_q [4];
	logic [LIMB_W-1:0] b_q [4];
	logic [LIMB_W-1:0] c_q [4];

	logic [WIDE_W-1:0] q1_q;
	logic [WIDE_W-1:0] q3_q;
	logic [WIDE_W-1:0] prodlo_q;
	logic [WIDE_W-1:0] t_q;
	logic [WIDE_W-1:0] res_q;

	logic [WIDE_W-1:0] a_full, b_full, c_full, x_src, y_src;
	logic [BUF_W-1:0]  digits;
	mac_cmd_t          cmd;

	logic [1:0]        in_idx;
	logic              in_acc, out_acc;
	logic [3:0]        k_nx, j_cur, last_col;
	logic [2:0]        imin_nx, imax;
	logic [WIDE_W:0]   cs_diff, fin_diff;
	logic [WIDE_W-1:0] fin_sum;

	assign in_idx  = s_tdata[1:0];
	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	assign a_full = {a_q[3] & TOP_MASK, a_q[2], a_q[1], a_q[0]};
	assign b_full = {b_q[3] & TOP_MASK, b_q[2], b_q[1], b_q[0]};
	assign c_full = {c_q[3] & TOP_MASK, c_q[2], c_q[1], c_q[0]};

	// Operand sources for the three products.
	always_comb begin
		case (phase_q)
			PH_AB: begin
				x_src = a_full;
				y_src = b_full;
			end
			PH_MU: begin
				x_src = q1_q;
				y_src = BARRETT_MU;
			end
			default: begin
				x_src = q3_q;
				y_src = ORDER_L;
			end
		endcase
	end

	// Column walk: column k sums x[i]*y[k-i] for i in [max(0,k-7), min(k,7)].
	assign imax     = (k_q < 4'd7) ? k_q[2:0] : 3'd7;
	assign k_nx     = k_q + 4'd1;
	assign imin_nx  = (k_nx > 4'd7) ? 3'(k_nx - 4'd7) : 3'd0;
	assign j_cur    = k_q - {1'b0, i_q};
	assign last_col = (phase_q == PH_L) ? 4'd7 : 4'd14;

	always_comb begin
		cmd.valid   = (state_q == ST_MUL);
		cmd.col_end = (state_q == ST_MUL) && (i_q == imax);
		cmd.col     = k_q;
		cmd.x       = x_src[i_q*DIG_W +: DIG_W];
		cmd.y       = y_src[j_cur[2:0]*DIG_W +: DIG_W];
		cmd.flush   = (state_q == ST_FLUSH);
	end

	scmsl_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.digits (digits)
	);

	// The subtract of l is shared by both conditional steps; the final step takes c - t and adds l on a borrow.
	assign cs_diff  = {1'b0, t_q} - {1'b0, ORDER_L};
	assign fin_diff = {1'b0, c_full} - {1'b0, t_q};
	assign fin_sum  = fin_diff[WIDE_W-1:0] + ORDER_L;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_AB;
			k_q     <= '0;
			i_q     <= '0;
			oidx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_idx == 2'd3) begin
						state_q <= ST_MUL;
						phase_q <= PH_AB;
						k_q     <= '0;
						i_q     <= '0;
					end
				end
				ST_MUL: begin
					if (i_q == imax) begin
						if (k_q == last_col) begin
							state_q <= ST_DRAIN;
						end else begin
							k_q <= k_nx;
							i_q <= imin_nx;
						end
					end else begin
						i_q <= i_q + 3'd1;
					end
				end
				ST_DRAIN: state_q <= ST_FLUSH;
				ST_FLUSH: state_q <= ST_NEXT;
				ST_NEXT: begin
					k_q <= '0;
					i_q <= '0;
					if (phase_q == PH_L) begin
						state_q <= ST_CS1;
					end else begin
						state_q <= ST_MUL;
						phase_q <= phase_q + 2'd1;
					end
				end
				ST_CS1: state_q <= ST_CS2;
				ST_CS2: state_q <= ST_FIN;
				ST_FIN: begin
					state_q <= ST_OUT;
					oidx_q  <= '0;
				end
				ST_OUT: begin
					if (out_acc) begin
						oidx_q <= oidx_q + 2'd1;
						if (oidx_q == 2'd3) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Limb storage and the wide datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q[in_idx] <= s_tdata[65:2];
			b_q[in_idx] <= s_tdata[129:66];
			c_q[in_idx] <= s_tdata[193:130];
		end
		if (state_q == ST_NEXT) begin
			case (phase_q)
				PH_AB: begin
					q1_q     <= digits[507:252];
					prodlo_q <= digits[WIDE_W-1:0];
				end
				PH_MU: q3_q <= digits[509:254];
				default: t_q <= prodlo_q - digits[WIDE_W-1:0];
			endcase
		end
		// Conditional subtract of l, kept only when it does not borrow.
		if ((state_q == ST_CS1 || state_q == ST_CS2) && !cs_diff[WIDE_W]) begin
			t_q <= cs_diff[WIDE_W-1:0];
		end
		if (state_q == ST_FIN) begin
			res_q <= fin_diff[WIDE_W] ? fin_sum : fin_diff[WIDE_W-1:0];
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast  = (oidx_q == 2'd3);
	assign m_tdata  = {6'd0, oidx_q, res_q[oidx_q*LIMB_W +: LIMB_W]};

	// The block never takes input while results are pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while results pending");

	// After the last result item is taken the block is ready again.
	a_back_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> s_tready)
		else $error("not ready after final result");

	// An item with limb_index 3 starts the multiply sequence.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_idx == 2'd3) |=> (state_q == ST_MUL && k_q == 4'd0))
		else $error("computation did not start");

	// Items with a lower index produce no result next cycle.
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_idx != 2'd3) |=> (s_tready && !m_tvalid))
		else $error("unexpected result after a storing item");

endmodule
`default_nettype wire

>>> rtl/scmsl_mac.sv
// Shared 32x32 multiplier with a column accumulator (product scanning).
// Writes one 32-bit result digit per finished column. Depends on scmsl_pkg.
`default_nettype none
module scmsl_mac import scmsl_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mac_cmd_t         cmd,
	output logic [BUF_W-1:0]      digits
);

	logic [2*DIG_W-1:0] p_s1;
	logic               v_s1;
	logic               end_s1;
	logic [3:0]         col_s1;
	logic [71:0]        acc_q;
	logic [BUF_W-1:0]   dig_q;
	logic [71:0]        sum;

	assign sum    = acc_q + {8'd0, p_s1};
	assign digits = dig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			end_s1 <= 1'b0;
			col_s1 <= '0;
		end else begin
			v_s1   <= cmd.valid;
			end_s1 <= cmd.col_end;
			col_s1 <= cmd.col;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= {32'd0, cmd.x} * {32'd0, cmd.y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.flush) begin
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= end_s1 ? {32'd0, sum[71:32]} : sum;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			dig_q[BUF_W-1 -: DIG_W] <= acc_q[DIG_W-1:0];
		end else if (v_s1 && end_s1) begin
			dig_q[col_s1*DIG_W +: DIG_W] <= sum[DIG_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> test/scalar_mulsub_mod_group_order_unit_test.sv
// Self-checking testbench for scalar_mulsub_mod_group_order_unit: s = (c - a*b) mod l.
// Drives limb items, predicts the result limbs by Barrett reduction and compares limb, index and last.
// Depends on scmsl_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none

class mulsub_scoreboard;
	logic [63:0] a_store [4];
	logic [63:0] b_store [4];
	logic [63:0] c_store [4];
	logic [63:0] limb_queue [$];
	logic [1:0]  index_queue [$];
	logic        last_queue [$];
	int          error_count;

	function new();
		error_count = 0;
		for (int k = 0; k < 4; k++) begin
			a_store[k] = '0;
			b_store[k] = '0;
			c_store[k] = '0;
		end
	endfunction

	// Barrett reduction of a*b followed by the subtraction from c.
	function logic [255:0] mulsub(logic [255:0] av, logic [255:0] bv, logic [255:0] cv);
		logic [511:0] prod;
		logic [511:0] q2;
		logic [255:0] q1;
		logic [255:0] q3;
		logic [255:0] t;
		logic [255:0] r;
		logic [511:0] r2;
		prod = av * bv;
		q1 = prod >> 252;
		q2 = q1 * scmsl_pkg::BARRETT_MU;
		q3 = q2 >> 254;
		r2 = q3 * scmsl_pkg::ORDER_L;
		t = prod[255:0] - r2[255:0];
		if (t >= scmsl_pkg::ORDER_L) t = t - scmsl_pkg::ORDER_L;
		if (t >= scmsl_pkg::ORDER_L) t = t - scmsl_pkg::ORDER_L;
		r = cv - t;
		if (cv < t) r = r + scmsl_pkg::ORDER_L;
		return r;
	endfunction

	function void note_limb(logic [1:0] idx, logic [63:0] a, logic [63:0] b, logic [63:0] c);
		logic [255:0] s;
		logic [255:0] av;
		logic [255:0] bv;
		logic [255:0] cv;
		a_store[idx] = a;
		b_store[idx] = b;
		c_store[idx] = c;
		if (idx != 2'd3) return;
		av = {a_store[3] & scmsl_pkg::TOP_MASK, a_store[2], a_store[1], a_store[0]};
		bv = {b_store[3] & scmsl_pkg::TOP_MASK, b_store[2], b_store[1], b_store[0]};
		cv = {c_store[3] & scmsl_pkg::TOP_MASK, c_store[2], c_store[1], c_store[0]};
		s = mulsub(av, bv, cv);
		for (int k = 0; k < 4; k++) begin
			limb_queue.push_back(s[64*k +: 64]);
			index_queue.push_back(2'(k));
			last_queue.push_back(k == 3);
		end
	endfunction

	function void check_result(logic [63:0] limb, logic [1:0] idx, logic last);
		logic [63:0] exp_limb;
		logic [1:0]  exp_idx;
		logic        exp_last;
		if (limb_queue.size() == 0) begin
			$error("result item with no expectation: limb %h", limb);
			error_count++;
			return;
		end
		exp_limb = limb_queue.pop_front();
		exp_idx = index_queue.pop_front();
		exp_last = last_queue.pop_front();
		if (limb !== exp_limb) begin
			$error("result_limb: expected %h, actual %h", exp_limb, limb);
			error_count++;
		end
		if (idx !== exp_idx) begin
			$error("result_index: expected %0d, actual %0d", exp_idx, idx);
			error_count++;
		end
		if (last !== exp_last) begin
			$error("last_limb: expected %0b, actual %0b", exp_last, last);
			error_count++;
		end
	endfunction

	function int pending();
		return limb_queue.size();
	endfunction
endclass

module scalar_mulsub_mod_group_order_unit_test;
	import scmsl_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [199:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic         m_tlast;

	mulsub_scoreboard board;
	int  idle_cycles;
	bit  long_hold;
	bit  timed_out;

	scalar_mulsub_mod_group_order_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		long_hold = 1'b0;
		timed_out = 1'b0;
		idle_cycles = 0;
	end

	function automatic logic [63:0] rand_limb();
		logic [63:0] v;
		v = {$urandom, $urandom};
		// Favor the corners often: all zeros, all ones, limbs near those of l.
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = ORDER_L[64*$urandom_range(0, 3) +: 64] + 64'($urandom_range(0, 2)) - 64'd1;
			default: ;
		endcase
		return v;
	endfunction

	// Scoreboarding on the accepted edges; checks and notes sample before the edge's updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_limb(s_tdata[1:0], s_tdata[65:2], s_tdata[129:66], s_tdata[193:130]);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata[63:0], m_tdata[65:64], m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// The receiver stalls on a random pattern, with an always-ready window; a long hold-off overrides it.
	initial begin
		int phase;
		bit [15:0] pattern;
		phase = 0;
		pattern = 16'($urandom);
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold)
				m_tready <= 1'b0;
			else begin
				m_tready <= (phase >= 96 && phase < 160) ? 1'b1 : pattern[phase % 16] | pattern[(phase + 3) % 16];
				phase = (phase + 1) % 256;
				if (phase == 0) pattern = 16'($urandom);
			end
		end
	end

	// Offers one item and waits until it is taken; tvalid stays high for a following item.
	task automatic send_limb(input logic [1:0] idx, input logic [63:0] a,
				input logic [63:0] b, input logic [63:0] c);
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, c, b, a, idx};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_operands(input logic [255:0] a, input logic [255:0] b,
				input logic [255:0] c);
		for (int k = 0; k < 4; k++)
			send_limb(2'(k), a[64*k +: 64], b[64*k +: 64], c[64*k +: 64]);
	endtask

	// Drops tvalid and idles the sender; a zero count leaves the input untouched.
	task automatic hold_input(input int cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic sender_gap();
		hold_input($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0);
	endtask

	task automatic wait_drained();
		if (board.pending() != 0) begin
			s_tvalid <= 1'b0;
			while (board.pending() != 0) @(posedge clk);
		end
	endtask

	initial begin
		logic [255:0] ra;
		logic [255:0] rb;
		logic [255:0] rc;
		int burst;
		int order [4];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zeros, all ones (masked), l and l-1, unreduced c above l.
		send_operands('0, '0, '0);
		send_operands('1, '1, '1);
		send_operands(ORDER_L, 256'd1, ORDER_L - 256'd1);
		send_operands(ORDER_L - 256'd1, ORDER_L - 256'd1, '0);
		send_operands(256'd1, 256'd1, '1);
		// Repeated and out-of-order limbs: the latest write per position wins.
		send_limb(2'd2, '1, 64'd5, '0);
		send_limb(2'd0, 64'd7, '1, 64'd3);
		send_limb(2'd0, 64'd9, '1, '1);
		send_limb(2'd1, '0, 64'd2, '1);
		send_limb(2'd3, 64'h0123456789abcdef, '1, '1);
		// Stored limbs stay valid: a lone index-3 item recomputes.
		send_limb(2'd3, '1, '0, 64'h1000000000000000);
		wait_drained();

		// Long receiver hold-off while the sender keeps offering items.
		fork
			begin
				long_hold = 1'b1;
				repeat (600) @(posedge clk);
				long_hold = 1'b0;
			end
			for (int n = 0; n < 3; n++)
				send_operands({rand_limb(), rand_limb(), rand_limb(), rand_limb()},
					{rand_limb(), rand_limb(), rand_limb(), rand_limb()},
					{rand_limb(), rand_limb(), rand_limb(), rand_limb()});
		join

		// Random part: mostly complete operand sets, some shuffled or repeated limbs.
		for (int n = 0; n < 330; ) begin
			burst = $urandom_range(1, 8);
			for (int m = 0; m < burst && n < 330; m++) begin
				ra = {rand_limb(), rand_limb(), rand_limb(), rand_limb()};
				rb = {rand_limb(), rand_limb(), rand_limb(), rand_limb()};
				rc = {rand_limb(), rand_limb(), rand_limb(), rand_limb()};
				if ($urandom_range(0, 4) != 0) begin
					send_operands(ra, rb, rc);
					n += 4;
				end else begin
					int cnt;
					cnt = $urandom_range(1, 4);
					for (int j = 0; j < cnt; j++) begin
						order[j] = $urandom_range(0, 2);
						send_limb(2'(order[j]), ra[64*j +: 64], rb[64*j +: 64], rc[64*j +: 64]);
						n++;
					end
					send_limb(2'd3, ra[255:192], rb[255:192], rc[255:192]);
					n++;
				end
			end
			if ($urandom_range(0, 9) == 0)
				wait_drained();
			else
				hold_input($urandom_range(0, 5));
			sender_gap();
		end

		wait_drained();
		hold_input(20);
		if (board.error_count == 0 && !timed_out)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: no item accepted on either side for too long.
	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end
endmodule

`default_nettype wire
